// File: design/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle as its antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Property holds in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // One received byte of the frame buffer
  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_last;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_done;
    logic [1:0] status;
  } out_item_t;

  // Parser result with its presence flag
  typedef struct packed {
    logic      have;
    out_item_t item;
  } res_t;

  // Header parse phases
  typedef enum logic [5:0] {
    PH_FIRST = 6'b000001,
    PH_CODE  = 6'b000010,
    PH_EXT   = 6'b000100,
    PH_KEY   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_TAIL  = 6'b100000
  } phase_t;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_OVER  = 2'd2;

  // Header constants
  localparam logic [6:0]  LEN_CODE_EXT16  = 7'd126;
  localparam logic [6:0]  LEN_CODE_EXT64  = 7'd127;
  localparam logic [3:0]  EXT16_BYTES     = 4'd2;
  localparam logic [3:0]  EXT64_BYTES     = 4'd8;
  localparam logic [3:0]  KEY_BYTES       = 4'd4;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4095;

endpackage

// File: design/wsd_in_reg.sv
// ----------------------------------------------------------------------------
// wsd_in_reg
// Input register: captures one item and holds it until the parser steps.
// ----------------------------------------------------------------------------
module wsd_in_reg import wsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     step,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // Free when empty or when the held item moves on this cycle
  assign in_ready = !valid_r || step;

  always_comb begin
    valid_nxt = valid_r;
    if (step) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: design/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header state machine and payload unmasking, one byte per step.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        step,
  input  in_item_t    item,
  output res_t        res
);

`include "assert_macros.svh"

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hc_r, hc_nxt;
  logic        mask_r, mask_nxt;
  logic [15:0] len_lo_r, len_lo_nxt;
  logic        len_hi_r, len_hi_nxt;
  logic [7:0]  key_r [4];
  logic [7:0]  key_nxt [4];
  logic [15:0] left_r, left_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic [15:0] max_r;

  logic [7:0]  b;
  logic [6:0]  code;
  logic        mask_eff;
  logic [15:0] cand_lo;
  logic        cand_hi;
  logic        len_done;
  logic        hdr_done;
  logic [15:0] fin_lo;
  logic        fin_hi;
  logic [1:0]  key_wr;

  assign b    = item.in_byte;
  assign code = b[6:0];

  // Length candidate after this byte
  always_comb begin
    cand_lo = len_lo_r;
    cand_hi = len_hi_r;
    case (phase_r)
      PH_CODE: begin
        // Extended codes start the length from zero
        cand_lo = ((code == LEN_CODE_EXT16) || (code == LEN_CODE_EXT64)) ?
                  16'd0 : {9'd0, code};
        cand_hi = 1'b0;
      end
      PH_EXT: begin
        cand_lo = {len_lo_r[7:0], b};
        cand_hi = len_hi_r || (len_lo_r[15:8] != 8'd0);
      end
      default: begin
        cand_lo = len_lo_r;
        cand_hi = len_hi_r;
      end
    endcase
  end

  assign mask_eff = (phase_r == PH_CODE) ? b[7] : mask_r;
  assign len_done = ((phase_r == PH_CODE) && (code != LEN_CODE_EXT16) &&
                     (code != LEN_CODE_EXT64)) ||
                    ((phase_r == PH_EXT) && (hc_r == 4'd1));
  assign hdr_done = (len_done && !mask_eff) ||
                    ((phase_r == PH_KEY) && (hc_r == 4'd1));
  assign fin_lo   = (phase_r == PH_KEY) ? len_lo_r : cand_lo;
  assign fin_hi   = (phase_r == PH_KEY) ? len_hi_r : cand_hi;
  // Key byte slot counts up as the remaining count goes 4, 3, 2, 1
  assign key_wr   = 2'(~hc_r[1:0] + 2'd1);

  // Advance the parse state for one byte
  always_comb begin
    phase_nxt  = phase_r;
    hc_nxt     = hc_r;
    mask_nxt   = mask_r;
    len_lo_nxt = cand_lo;
    len_hi_nxt = cand_hi;
    key_nxt    = key_r;
    left_nxt   = left_r;
    kidx_nxt   = kidx_r;
    res        = '0;

    case (phase_r)
      PH_FIRST: begin
        phase_nxt = PH_CODE;
      end
      PH_CODE: begin
        mask_nxt = b[7];
        if (code == LEN_CODE_EXT16) begin
          hc_nxt    = EXT16_BYTES;
          phase_nxt = PH_EXT;
        end else if (code == LEN_CODE_EXT64) begin
          hc_nxt    = EXT64_BYTES;
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        hc_nxt = 4'(hc_r - 4'd1);
      end
      PH_KEY: begin
        key_nxt[key_wr] = b;
        hc_nxt          = 4'(hc_r - 4'd1);
      end
      PH_DATA: begin
        res.have              = 1'b1;
        res.item.byte_valid   = 1'b1;
        res.item.payload_byte = mask_r ? (b ^ key_r[kidx_r]) : b;
        kidx_nxt              = 2'(kidx_r + 2'd1);
        left_nxt              = 16'(left_r - 16'd1);
        if (left_r == 16'd1) begin
          res.item.frame_done = 1'b1;
          phase_nxt           = PH_TAIL;
        end
      end
      default: begin
        phase_nxt = PH_TAIL;
      end
    endcase

    // Length known: fetch the key when masked
    if (len_done && mask_eff) begin
      hc_nxt    = KEY_BYTES;
      phase_nxt = PH_KEY;
    end

    // Header complete: check capacity and start the payload
    if (hdr_done) begin
      if (fin_hi || (fin_lo > max_r)) begin
        res.have            = 1'b1;
        res.item.frame_done = 1'b1;
        res.item.status     = STATUS_OVER;
        phase_nxt           = PH_TAIL;
      end else if (fin_lo == 16'd0) begin
        res.have            = 1'b1;
        res.item.frame_done = 1'b1;
        res.item.status     = STATUS_OK;
        phase_nxt           = PH_TAIL;
      end else begin
        left_nxt  = fin_lo;
        kidx_nxt  = 2'd0;
        phase_nxt = PH_DATA;
      end
    end

    // Buffer end: flag an unfinished or oversized frame as short, then expect a new one
    if (item.buffer_last) begin
      if ((phase_nxt != PH_TAIL) || (res.item.status == STATUS_OVER)) begin
        res.have            = 1'b1;
        res.item.frame_done = 1'b1;
        res.item.status     = STATUS_SHORT;
      end
      phase_nxt = PH_FIRST;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      hc_r     <= 4'd0;
      mask_r   <= 1'b0;
      len_lo_r <= 16'd0;
      len_hi_r <= 1'b0;
      left_r   <= 16'd0;
      kidx_r   <= 2'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      hc_r     <= hc_nxt;
      mask_r   <= mask_nxt;
      len_lo_r <= len_lo_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
      kidx_r   <= kidx_nxt;
    end
  end

  // Mask key bytes are all rewritten before use
  always_ff @(posedge clk) begin
    if (step) begin
      key_r <= key_nxt;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  `ASSERT_IMPL(a_data_only_in_payload, step && res.have && res.item.byte_valid, phase_r == PH_DATA, "payload byte outside payload phase")
  `ASSERT_IMPL(a_key_count_range, phase_r == PH_KEY, (hc_r != 4'd0) && (hc_r <= KEY_BYTES), "key byte count out of range")
  `ASSERT_IMPL(a_payload_left_nonzero, phase_r == PH_DATA, left_r != 16'd0, "payload phase with nothing left")

endmodule

// File: design/wsd_out_reg.sv
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module wsd_out_reg import wsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  res_t      res,
  output logic      step,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

`include "assert_macros.svh"

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;
  logic      load;

  // Step the parser when an item is held and the result slot is free or draining
  assign step = item_valid && (!valid_r || out_ready);
  assign load = step && res.have;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res.item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  `ASSERT_NEXT(a_load_shows_result, load, valid_r, "loaded result not presented")

endmodule

// File: design/websocket_frame_deframer.sv
// One byte per cycle while the result register is free or draining; the
// header state machine and the unmask XOR are combinational between the
// input and result registers. Header bytes give a result only when they
// end the header of an empty or oversized frame or end the buffer early;
// trailing bytes give none. Reset (synchronous, rst_n low) returns to the
// first header byte, empties both registers and sets max_payload to 4095.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses frame headers from a byte stream and emits unmasked payload bytes.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic     step;
  logic     item_valid;
  in_item_t item;
  res_t     res;

  // Input register
  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .step       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  // Header parser and unmask
  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .res       (res)
  );

  // Result register
  wsd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .step       (step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
